// ----- design/cmt_pkg.sv -----
// Shared types, constants and arithmetic helpers for the capsule mesh tessellator.
`default_nettype none
package cmt_pkg;

  localparam int INDEX_BITS = 32;
  localparam int VERTS      = 14;
  localparam int TRIS       = 24;

  typedef struct packed {
    logic start;
    logic is_root;
  } rd_ctrl_t;

  function automatic logic signed [31:0] sin_q30(input logic [3:0] k);
    logic signed [31:0] r;
    begin
      unique case (k)
        4'd0:    r = 32'sd0;
        4'd1:    r = 32'sd536865851;
        4'd2:    r = 32'sd929881853;
        4'd3:    r = 32'sd1073741824;
        4'd4:    r = 32'sd929899384;
        4'd5:    r = 32'sd536896215;
        4'd6:    r = 32'sd35062;
        4'd7:    r = -32'sd536835487;
        4'd8:    r = -32'sd929864321;
        4'd9:    r = -32'sd1073741823;
        4'd10:   r = -32'sd929916913;
        4'd11:   r = -32'sd536926579;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] cos_q30(input logic [3:0] k);
    logic signed [31:0] r;
    begin
      unique case (k)
        4'd0:    r = 32'sd1073741824;
        4'd1:    r = 32'sd929890618;
        4'd2:    r = 32'sd536881033;
        4'd3:    r = 32'sd17531;
        4'd4:    r = -32'sd536850669;
        4'd5:    r = -32'sd929873087;
        4'd6:    r = -32'sd1073741823;
        4'd7:    r = -32'sd929908149;
        4'd8:    r = -32'sd536911397;
        4'd9:    r = -32'sd52592;
        4'd10:   r = 32'sd536820304;
        4'd11:   r = 32'sd929855555;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

  // round to nearest, ties away from zero: bias negatives by one less than half
  function automatic logic signed [63:0] rshr30(input logic signed [63:0] v);
    logic signed [63:0] bias;
    begin
      bias = v[63] ? 64'sd536870911 : 64'sd536870912;
      return (v + bias) >>> 30;
    end
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      else if (v < -64'sd2147483648) return 32'h8000_0000;
      else return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- design/cmt_root_div.sv -----
// Iterative 32-step unit: floor square root of 64 bits or 64 by 32 bit division.
`default_nettype none
module cmt_root_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmt_pkg::rd_ctrl_t ctrl,
  input  wire logic [63:0]      opa,
  input  wire logic [31:0]      opb,
  output logic                  done,
  output logic [31:0]           result
);

  logic        busy_r;
  logic        root_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] x_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [31:0] d_r;

  logic [63:0] trial;
  logic [64:0] sh;
  logic [32:0] top;
  logic        ge;
  logic [32:0] topn;

  always_comb begin
    trial = res_r + bit_r;
    sh    = {x_r, 1'b0};
    top   = sh[64:32];
    ge    = top >= {1'b0, d_r};
    topn  = ge ? top - {1'b0, d_r} : top;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      root_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd31);
      if (ctrl.start) begin
        busy_r <= 1'b1;
        root_r <= ctrl.is_root;
        cnt_r  <= '0;
        x_r    <= opa;
        res_r  <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
        d_r    <= opb;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) busy_r <= 1'b0;
        if (root_r) begin
          if (x_r >= trial) begin
            x_r   <= x_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          x_r <= {topn[31:0], sh[31:1], ge};
        end
      end
    end
  end

  assign done   = done_r;
  assign result = root_r ? res_r[31:0] : x_r[31:0];

endmodule
`default_nettype wire

// ----- design/capsule_mesh_tessellator_unit.sv -----
// Top level of the capsule mesh tessellator: sequencer, shared multiplier and output stage.
//
// Usage: one segment beat on the in_ channel (start and end centres, radius, colour)
// yields 38 beats on the out_ channel: 24 triangle records (out_tuser 0) carrying
// three vertex indices offset by a running vertex base, then 14 vertex records
// (out_tuser 1) carrying saturated Q16.16 coordinates and the colour; out_tlast
// marks the final vertex. The vertex base advances by 14 per segment and wraps.
// cfg_wen/cfg_wdata set capsule mode (tips pushed out by the radius) or cylinder.
// The block takes one segment at a time: in_tready is high only when idle.
// The sequencer is built around the single 32-step root/divide unit (one square
// root and three divisions per unit vector, two unit vectors; a zero-length
// segment uses none) and the single 33x33 multiplier shared by every product.
// A one-beat output register holds a record while the receiver stalls; the
// sequencer waits on it and resumes when it is taken.
// Reset clears the vertex base to zero, sets capsule mode and empties the output.
`default_nettype none
module capsule_mesh_tessellator_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, seg_radius,
  // in_red, in_green, in_blue, in_alpha, zero pad
  input  wire logic [255:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // coord_x, coord_y, coord_z, corner_a, corner_b, corner_c,
  // out_red, out_green, out_blue, out_alpha
  output logic [223:0]      out_tdata,
  // kind
  output logic              out_tuser,
  output logic              out_tlast,
  input  wire logic         cfg_wen,
  input  wire logic         cfg_wdata
);

  localparam int IB = cmt_pkg::INDEX_BITS;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_NORM  = 5'd1;
  localparam logic [4:0] S_SQ_M  = 5'd2;
  localparam logic [4:0] S_SQ_A  = 5'd3;
  localparam logic [4:0] S_RT_GO = 5'd4;
  localparam logic [4:0] S_RT_WT = 5'd5;
  localparam logic [4:0] S_DV_GO = 5'd6;
  localparam logic [4:0] S_DV_WT = 5'd7;
  localparam logic [4:0] S_CROSS = 5'd8;
  localparam logic [4:0] S_S2_M1 = 5'd9;
  localparam logic [4:0] S_S2_A1 = 5'd10;
  localparam logic [4:0] S_S2_A2 = 5'd11;
  localparam logic [4:0] S_TRI   = 5'd12;
  localparam logic [4:0] S_VA    = 5'd13;
  localparam logic [4:0] S_VB    = 5'd14;
  localparam logic [4:0] S_VC    = 5'd15;
  localparam logic [4:0] S_VD    = 5'd16;
  localparam logic [4:0] S_VE    = 5'd17;
  localparam logic [4:0] S_VOUT  = 5'd18;

  logic [4:0]          state_r;
  logic signed [31:0]  p1_r [3];
  logic signed [31:0]  p2_r [3];
  logic signed [31:0]  dir_r [3];
  logic signed [31:0]  s1_r [3];
  logic signed [31:0]  s2_r [3];
  logic [31:0]         crd_r [3];
  logic [33:0]         m_r [3];
  logic [2:0]          neg_r;
  logic [30:0]         rad_r;
  logic [31:0]         col_r;
  logic [1:0]          idx_r;
  logic                pass_r;
  logic signed [63:0]  acc_r;
  logic [31:0]         len_r;
  logic signed [32:0]  w_r;
  logic signed [65:0]  prod_r;
  logic [2:0]          tu_r;
  logic [1:0]          tj_r;
  logic [3:0]          v_r;
  logic [IB-1:0]       base_r;
  logic                cap_r;
  logic                out_valid_r;
  logic [223:0]        out_data_r;
  logic                out_kind_r;
  logic                out_last_r;

  cmt_pkg::rd_ctrl_t   rd_ctrl;
  logic [63:0]         rd_opa;
  logic                rd_done;
  logic [31:0]         rd_result;

  logic                slot_free;
  logic                out_load;
  logic [1:0]          i_next;
  logic [1:0]          i_prev;
  logic [1:0]          sel_s1;
  logic [1:0]          sel_dir;
  logic signed [31:0]  s1_sel;
  logic signed [31:0]  dir_sel;
  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic [33:0]         mx;
  logic                is_tip;
  logic [3:0]          ring_k;
  logic signed [34:0]  in_d [3];
  logic signed [34:0]  cr [3];
  logic signed [34:0]  dx [3];
  logic [2:0]          ta;
  logic [3:0]          off_a;
  logic [3:0]          off_b;
  logic [3:0]          off_c;
  logic signed [63:0]  rr;
  logic signed [63:0]  rr_tip;
  logic signed [63:0]  ctr;
  logic signed [63:0]  vsum;

  assign slot_free = !out_valid_r || out_tready;
  assign out_load  = slot_free && (state_r == S_TRI || state_r == S_VOUT);

  assign i_next = (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
  assign i_prev = (idx_r == 2'd0) ? 2'd2 : idx_r - 2'd1;
  assign sel_s1  = (state_r == S_S2_M1) ? i_next : (state_r == S_S2_A1) ? i_prev : idx_r;
  assign sel_dir = (state_r == S_S2_M1) ? i_prev : (state_r == S_S2_A1) ? i_next : idx_r;
  assign s1_sel  = s1_r[sel_s1];
  assign dir_sel = dir_r[sel_dir];

  assign is_tip = v_r >= 4'd12;
  assign ring_k = (v_r < 4'd6) ? {v_r[2:0], 1'b0} : {v_r[2:0] - 3'd6, 1'b0} + 4'd1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ_M: begin
        mul_a = 33'(m_r[idx_r]);
        mul_b = 33'(m_r[idx_r]);
      end
      S_S2_M1, S_S2_A1, S_VA: begin
        mul_a = 33'(s1_sel);
        mul_b = (state_r == S_VA) ? 33'(cmt_pkg::sin_q30(ring_k)) : 33'(dir_sel);
      end
      S_VB: begin
        mul_a = 33'(s2_r[idx_r]);
        mul_b = 33'(cmt_pkg::cos_q30(ring_k));
      end
      S_VD: begin
        mul_a = $signed({2'b00, rad_r});
        mul_b = is_tip ? 33'(dir_sel) : w_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    mx = m_r[0];
    if (m_r[1] > mx) mx = m_r[1];
    if (m_r[2] > mx) mx = m_r[2];
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      in_d[j] = 35'($signed(in_tdata[96 + 32*j +: 32])) - 35'($signed(in_tdata[32*j +: 32]));
      dx[j]   = 35'(dir_r[j]);
    end
    cr[0] = (dx[1] <<< 1) + dx[1] - (dx[2] <<< 1);
    cr[1] = dx[2] - (dx[0] <<< 1) - dx[0];
    cr[2] = (dx[0] <<< 1) - dx[1];
  end

  always_comb begin
    ta = (tu_r == 3'd5) ? 3'd0 : tu_r + 3'd1;
    unique case (tj_r)
      2'd0: begin
        off_a = 4'd12;
        off_b = {1'b0, tu_r};
        off_c = {1'b0, ta};
      end
      2'd1: begin
        off_a = 4'd13;
        off_b = {1'b0, ta} + 4'd6;
        off_c = {1'b0, tu_r} + 4'd6;
      end
      2'd2: begin
        off_a = {1'b0, tu_r};
        off_b = {1'b0, tu_r} + 4'd6;
        off_c = {1'b0, ta};
      end
      default: begin
        off_a = {1'b0, ta} + 4'd6;
        off_b = {1'b0, ta};
        off_c = {1'b0, tu_r} + 4'd6;
      end
    endcase
  end

  always_comb begin
    rr     = cmt_pkg::rshr30(64'(prod_r));
    rr_tip = cap_r ? rr : 64'sd0;
    ctr    = (v_r >= 4'd6 && v_r != 4'd12) ? 64'(p2_r[idx_r]) : 64'(p1_r[idx_r]);
    if (v_r == 4'd12) vsum = ctr - rr_tip;
    else if (v_r == 4'd13) vsum = ctr + rr_tip;
    else vsum = ctr + rr;
  end

  assign rd_ctrl.start   = (state_r == S_RT_GO) || (state_r == S_DV_GO);
  assign rd_ctrl.is_root = (state_r == S_RT_GO);
  assign rd_opa = (state_r == S_RT_GO) ? acc_r
                : ((64'(m_r[idx_r]) << 30) + 64'(len_r >> 1));

  cmt_root_div u_root_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (rd_ctrl),
    .opa    (rd_opa),
    .opb    (len_r),
    .done   (rd_done),
    .result (rd_result)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      cap_r       <= 1'b1;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      pass_r      <= 1'b0;
      tu_r        <= '0;
      tj_r        <= '0;
      v_r         <= '0;
    end else begin
      if (cfg_wen) cap_r <= cfg_wdata;
      out_valid_r <= out_load || (out_valid_r && !out_tready);

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            for (int j = 0; j < 3; j++) begin
              p1_r[j]  <= $signed(in_tdata[32*j +: 32]);
              p2_r[j]  <= $signed(in_tdata[96 + 32*j +: 32]);
              m_r[j]   <= in_d[j][34] ? 34'(-in_d[j]) : 34'(in_d[j]);
              neg_r[j] <= in_d[j][34];
            end
            rad_r   <= in_tdata[222:192];
            col_r   <= in_tdata[254:223];
            pass_r  <= 1'b0;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (mx == '0) begin
            for (int j = 0; j < 3; j++) begin
              if (pass_r) s1_r[j] <= '0;
              else dir_r[j] <= '0;
            end
            idx_r   <= '0;
            state_r <= pass_r ? S_S2_M1 : S_CROSS;
          end else if (mx >= 34'(1 << 30)) begin
            for (int j = 0; j < 3; j++) m_r[j] <= m_r[j] >> 1;
          end else if (mx < 34'(1 << 29)) begin
            for (int j = 0; j < 3; j++) m_r[j] <= m_r[j] << 1;
          end else begin
            idx_r   <= '0;
            acc_r   <= '0;
            state_r <= S_SQ_M;
          end
        end
        S_SQ_M: state_r <= S_SQ_A;
        S_SQ_A: begin
          acc_r <= acc_r + 64'(prod_r);
          if (idx_r == 2'd2) begin
            state_r <= S_RT_GO;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_SQ_M;
          end
        end
        S_RT_GO: state_r <= S_RT_WT;
        S_RT_WT: begin
          if (rd_done) begin
            len_r   <= rd_result;
            idx_r   <= '0;
            state_r <= S_DV_GO;
          end
        end
        S_DV_GO: state_r <= S_DV_WT;
        S_DV_WT: begin
          if (rd_done) begin
            if (pass_r) s1_r[idx_r] <= neg_r[idx_r] ? -rd_result : rd_result;
            else dir_r[idx_r] <= neg_r[idx_r] ? -rd_result : rd_result;
            if (idx_r == 2'd2) begin
              idx_r   <= '0;
              state_r <= pass_r ? S_S2_M1 : S_CROSS;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_DV_GO;
            end
          end
        end
        S_CROSS: begin
          for (int j = 0; j < 3; j++) begin
            m_r[j]   <= cr[j][34] ? 34'(-cr[j]) : 34'(cr[j]);
            neg_r[j] <= cr[j][34];
          end
          pass_r  <= 1'b1;
          state_r <= S_NORM;
        end
        S_S2_M1: state_r <= S_S2_A1;
        S_S2_A1: begin
          acc_r   <= 64'(prod_r);
          state_r <= S_S2_A2;
        end
        S_S2_A2: begin
          s2_r[idx_r] <= 32'(cmt_pkg::rshr30(acc_r - 64'(prod_r)));
          if (idx_r == 2'd2) begin
            idx_r   <= '0;
            tu_r    <= '0;
            tj_r    <= '0;
            state_r <= S_TRI;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_S2_M1;
          end
        end
        S_TRI: begin
          if (slot_free) begin
            out_kind_r <= 1'b0;
            out_last_r <= 1'b0;
            out_data_r <= {32'd0,
                           32'(base_r + IB'(off_c)),
                           32'(base_r + IB'(off_b)),
                           32'(base_r + IB'(off_a)),
                           96'd0};
            tj_r <= tj_r + 2'd1;
            if (tj_r == 2'd3) begin
              if (tu_r == 3'd5) begin
                v_r     <= '0;
                idx_r   <= '0;
                state_r <= S_VA;
              end else begin
                tu_r <= tu_r + 3'd1;
              end
            end
          end
        end
        S_VA: state_r <= is_tip ? S_VD : S_VB;
        S_VB: begin
          acc_r   <= 64'(prod_r);
          state_r <= S_VC;
        end
        S_VC: begin
          w_r     <= 33'(cmt_pkg::rshr30(acc_r + 64'(prod_r)));
          state_r <= S_VD;
        end
        S_VD: state_r <= S_VE;
        S_VE: begin
          crd_r[idx_r] <= cmt_pkg::sat32(vsum);
          if (idx_r == 2'd2) begin
            idx_r   <= '0;
            state_r <= S_VOUT;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_VA;
          end
        end
        S_VOUT: begin
          if (slot_free) begin
            out_kind_r <= 1'b1;
            out_last_r <= (v_r == 4'd13);
            out_data_r <= {col_r, 96'd0, crd_r[2], crd_r[1], crd_r[0]};
            if (v_r == 4'd13) begin
              base_r  <= base_r + IB'(cmt_pkg::VERTS);
              state_r <= S_IDLE;
            end else begin
              v_r     <= v_r + 4'd1;
              state_r <= S_VA;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_last_is_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last flag on a triangle record");

  a_tri_no_coords: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[95:0] == 96'd0)
    else $error("triangle record carries coordinates");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("segment taken while busy");

  a_idle_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("idle with a segment's records still pending");

endmodule
`default_nettype wire
